// ----- rtl/audio_page_window_table_defines.svh -----
// ----------------------------------------------------------------------------
// audio page window table assertion macros
// shared property forms for the page table checks
// ----------------------------------------------------------------------------
`ifndef AUDIO_PAGE_WINDOW_TABLE_DEFINES_SVH
`define AUDIO_PAGE_WINDOW_TABLE_DEFINES_SVH

// condition implies expression in the same cycle
`define APWT_ASSERT_NOW(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("apwt same-cycle check failed");

// condition implies expression in the next cycle
`define APWT_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("apwt next-cycle check failed");

`endif

// ----- rtl/apwt_pkg.sv -----
// ----------------------------------------------------------------------------
// apwt_pkg
// types and constants of the audio page window table
// ----------------------------------------------------------------------------
`default_nettype none

package apwt_pkg;

	localparam int MAX_PAGES = 8;
	localparam int IDX_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int NCNT_W    = $clog2(MAX_PAGES + 1);
	localparam int FRAME_W   = 48;
	localparam int GEN_W     = 32;
	localparam int COUNT_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [3:0]  ACTIVE_PAGES_RESET = 4'd8;
	localparam logic [15:0] PAGE_FRAMES_RESET  = 16'd4096;

	typedef enum logic [2:0] {
		OP_BEGIN_FILL  = 3'd0,
		OP_CANCEL_FILL = 3'd1,
		OP_PUBLISH     = 3'd2,
		OP_RETIRE      = 3'd3,
		OP_LOOKUP      = 3'd4,
		OP_QUERY       = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		PS_EMPTY   = 3'd0,
		PS_FILLING = 3'd1,
		PS_READY   = 3'd2,
		PS_RETIRED = 3'd4
	} pstate_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_PAGES = 1'b0,
		CFG_PAGE_FRAMES  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_SCAN,
		FS_FINISH
	} fsm_t;

	typedef struct packed {
		logic [2:0]         operation;
		logic [7:0]         page;
		logic [GEN_W-1:0]   stream_gen;
		logic [GEN_W-1:0]   audio_generation;
		logic [FRAME_W-1:0] first_frame;
		logic [COUNT_W-1:0] frame_total;
		logic               final_flag;
		logic [FRAME_W-1:0] seek_frame;
		logic [FRAME_W-1:0] gap_limit;
	} apwt_cmd_t;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         state_code;
		logic [7:0]         hit_page;
		logic [COUNT_W-1:0] page_offset;
		logic [FRAME_W-1:0] hit_start;
		logic [COUNT_W-1:0] hit_frames;
		logic               hit_final;
		logic [FRAME_W-1:0] miss_gap;
	} apwt_result_t;

endpackage

`default_nettype wire

// ----- rtl/audio_page_window_table.sv -----
// ----------------------------------------------------------------------------
// audio_page_window_table
// page state table with descriptor scan for publish overlap and frame lookup
// ----------------------------------------------------------------------------
// usage:
//   a command is taken at a rising edge with start high and busy low; busy
//   stays high until the command is finished. the result appears on result
//   for exactly one cycle with done high and is a transfer at that edge;
//   there is no back-pressure on the result side.
//   cfg_we writes active_pages (index 0) or the frame capacity (index 1) at
//   once; write only while busy is low and no result is pending.
// sequencing:
//   fill, cancel, retire, query and unknown codes go from the accepting edge
//   straight to the finish state, which registers the result and done. with
//   n = min(active_pages, 8) above zero, publish and lookup first walk the n
//   active pages through one shared compare/subtract unit, one page a cycle;
//   a lookup hit or an overlap ends the walk early. one command is in flight
//   at a time: a new command is taken only once busy is low again.
// reset:
//   arst_n clears all page states to empty, restores active_pages 8 and
//   frame capacity 4096 and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_page_window_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire apwt_pkg::apwt_cmd_t         cmd,
	output logic                             done,
	output apwt_pkg::apwt_result_t           result,
	input  wire logic                        cfg_we,
	input  wire logic [apwt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [apwt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import apwt_pkg::*;

	`include "audio_page_window_table_defines.svh"

	// configuration
	logic [3:0]         active_q;
	logic [COUNT_W-1:0] frames_cfg_q;

	// page table
	pstate_t            page_states_q [MAX_PAGES];
	logic [GEN_W-1:0]   desc_gen_q    [MAX_PAGES];
	logic [FRAME_W-1:0] desc_start_q  [MAX_PAGES];
	logic [FRAME_W-1:0] desc_end_q    [MAX_PAGES];
	logic [COUNT_W-1:0] desc_frames_q [MAX_PAGES];
	logic               desc_final_q  [MAX_PAGES];
	logic [GEN_W-1:0]   retire_after_q [MAX_PAGES];

	// command context
	fsm_t               state_q, state_d;
	apwt_cmd_t          cmd_q;
	op_t                op_q;
	logic [NCNT_W-1:0]  n_q;
	logic               valid_q;
	logic               pre_ok_q;
	logic [FRAME_W-1:0] end_q;
	logic               limit_nz_q;
	logic [IDX_W-1:0]   scan_q;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic               overlap_q;
	logic [FRAME_W-1:0] gap_q;
	apwt_result_t       res_q;
	logic               done_q;

	// control
	logic               load;
	logic               scan_step;
	logic               finish;

	// accept-side precompute
	logic [NCNT_W-1:0]  n_next;
	logic               valid_next;
	logic [FRAME_W:0]   end_sum;
	logic               pre_ok_next;
	op_t                op_next;
	logic               scan_next;

	// shared read port
	logic [IDX_W-1:0]   p_idx;
	logic [IDX_W-1:0]   rd_idx;
	pstate_t            rd_state;
	logic [GEN_W-1:0]   rd_gen;
	logic [FRAME_W-1:0] rd_start;
	logic [FRAME_W-1:0] rd_end;
	logic [COUNT_W-1:0] rd_frames;
	logic               rd_final;
	logic [GEN_W-1:0]   rd_retire;

	// scan unit
	logic               ent_match;
	logic               src_ge;
	logic               src_lt_end;
	logic [FRAME_W-1:0] cand_gap;
	logic               hit_now;
	logic               overlap_now;
	logic               gap_upd;
	logic               scan_last;
	logic               scan_stop;

	// finish datapath
	logic               op_ok;
	apwt_result_t       res_d;

	assign busy   = (state_q != FS_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// --- accept-side ---------------------------------------------------------
	always_comb begin
		if (int'(active_q) > MAX_PAGES) begin
			n_next = NCNT_W'(MAX_PAGES);
		end else begin
			n_next = NCNT_W'(active_q);
		end
		valid_next  = int'(cmd.page) < int'(n_next);
		end_sum     = {1'b0, cmd.first_frame} +
			{{(FRAME_W + 1 - COUNT_W){1'b0}}, cmd.frame_total};
		pre_ok_next = (cmd.stream_gen != '0) && (cmd.frame_total != '0) &&
			(cmd.frame_total <= frames_cfg_q) && !end_sum[FRAME_W];
		op_next     = op_t'(cmd.operation);
		scan_next   = ((op_next == OP_PUBLISH) || (op_next == OP_LOOKUP)) && (n_next != '0);
	end

	// --- read port -------------------------------------------------------------
	assign p_idx = cmd_q.page[IDX_W-1:0];

	always_comb begin
		if (state_q == FS_SCAN) begin
			rd_idx = scan_q;
		end else if (op_q == OP_LOOKUP) begin
			rd_idx = hit_idx_q;
		end else begin
			rd_idx = p_idx;
		end
		rd_state  = page_states_q[rd_idx];
		rd_gen    = desc_gen_q[rd_idx];
		rd_start  = desc_start_q[rd_idx];
		rd_end    = desc_end_q[rd_idx];
		rd_frames = desc_frames_q[rd_idx];
		rd_final  = desc_final_q[rd_idx];
		rd_retire = retire_after_q[rd_idx];
	end

	// --- scan unit: one page per cycle -----------------------------------------
	always_comb begin
		ent_match   = (rd_state == PS_READY) && (rd_gen == cmd_q.stream_gen);
		src_ge      = cmd_q.seek_frame >= rd_start;
		src_lt_end  = cmd_q.seek_frame < rd_end;
		cand_gap    = rd_start - cmd_q.seek_frame;
		hit_now     = (op_q == OP_LOOKUP) && ent_match && src_ge && src_lt_end;
		gap_upd     = (op_q == OP_LOOKUP) && ent_match && !src_ge && limit_nz_q &&
			(cand_gap < gap_q);
		// the page being published never overlaps itself
		overlap_now = (op_q == OP_PUBLISH) && ent_match && !(valid_q && scan_q == p_idx) &&
			(cmd_q.first_frame < rd_end) && (rd_start < end_q);
		scan_last   = (int'(scan_q) + 1) == int'(n_q);
		scan_stop   = scan_last || hit_now || overlap_now;
	end

	// --- sequencer -----------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		scan_step = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			FS_IDLE: begin
				if (start) begin
					load    = 1'b1;
					state_d = scan_next ? FS_SCAN : FS_FINISH;
				end
			end
			FS_SCAN: begin
				scan_step = 1'b1;
				if (scan_stop) begin
					state_d = FS_FINISH;
				end
			end
			FS_FINISH: begin
				finish  = 1'b1;
				state_d = FS_IDLE;
			end
			default: begin
				state_d = FS_IDLE;
			end
		endcase
	end

	// --- finish: decide, update table, form result -----------------------------
	always_comb begin
		op_ok = 1'b0;
		res_d = '0;
		unique case (op_q)
			OP_BEGIN_FILL: begin
				op_ok = valid_q && ((rd_state == PS_EMPTY) ||
					((rd_state == PS_RETIRED) && (cmd_q.audio_generation >= rd_retire)));
				res_d.accepted = op_ok;
			end
			OP_CANCEL_FILL: begin
				op_ok = valid_q && (rd_state == PS_FILLING);
				res_d.accepted = op_ok;
			end
			OP_PUBLISH: begin
				op_ok = valid_q && (rd_state == PS_FILLING) && pre_ok_q && !overlap_q;
				res_d.accepted = op_ok;
			end
			OP_RETIRE: begin
				op_ok = valid_q && (cmd_q.audio_generation != '0) && (rd_state == PS_READY);
				res_d.accepted = op_ok;
			end
			OP_LOOKUP: begin
				res_d.accepted = hit_q;
				if (hit_q) begin
					res_d.hit_page    = 8'(hit_idx_q);
					res_d.page_offset = cmd_q.seek_frame[COUNT_W-1:0] - rd_start[COUNT_W-1:0];
					res_d.hit_start   = rd_start;
					res_d.hit_frames  = rd_frames;
					res_d.hit_final   = rd_final;
				end else begin
					res_d.miss_gap = gap_q;
				end
			end
			OP_QUERY: begin
				res_d.accepted = valid_q;
				if (valid_q) begin
					res_d.state_code = rd_state;
				end
			end
			default: begin
				op_ok = 1'b0;
			end
		endcase
	end

	// page states carry reset; descriptors are only read once a page is ready or retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAGES; i++) begin
				page_states_q[i] <= PS_EMPTY;
			end
		end else if (finish && op_ok) begin
			unique case (op_q)
				OP_BEGIN_FILL:  page_states_q[p_idx] <= PS_FILLING;
				OP_CANCEL_FILL: page_states_q[p_idx] <= PS_EMPTY;
				OP_PUBLISH:     page_states_q[p_idx] <= PS_READY;
				OP_RETIRE:      page_states_q[p_idx] <= PS_RETIRED;
				default:        page_states_q[p_idx] <= page_states_q[p_idx];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish && op_ok && (op_q == OP_PUBLISH)) begin
			desc_gen_q[p_idx]    <= cmd_q.stream_gen;
			desc_start_q[p_idx]  <= cmd_q.first_frame;
			desc_end_q[p_idx]    <= end_q;
			desc_frames_q[p_idx] <= cmd_q.frame_total;
			desc_final_q[p_idx]  <= cmd_q.final_flag;
		end
		if (finish && op_ok && (op_q == OP_RETIRE)) begin
			retire_after_q[p_idx] <= cmd_q.audio_generation;
		end
	end

	// --- command context and scan accumulators ---------------------------------
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q      <= cmd;
			op_q       <= op_next;
			n_q        <= n_next;
			valid_q    <= valid_next;
			pre_ok_q   <= pre_ok_next;
			end_q      <= end_sum[FRAME_W-1:0];
			limit_nz_q <= (cmd.gap_limit != '0);
			gap_q      <= cmd.gap_limit;
			scan_q     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			overlap_q  <= 1'b0;
		end else if (scan_step) begin
			scan_q <= scan_q + 1'b1;
			if (hit_now) begin
				hit_q     <= 1'b1;
				hit_idx_q <= scan_q;
			end
			if (overlap_now) begin
				overlap_q <= 1'b1;
			end
			if (gap_upd) begin
				gap_q <= cand_gap;
			end
		end
	end

	// --- result and configuration ----------------------------------------------
	always_ff @(posedge clk) begin
		if (finish) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= ACTIVE_PAGES_RESET;
			frames_cfg_q <= PAGE_FRAMES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ACTIVE_PAGES: active_q     <= cfg_wdata[3:0];
				CFG_PAGE_FRAMES:  frames_cfg_q <= cfg_wdata[COUNT_W-1:0];
				default:          active_q     <= active_q;
			endcase
		end
	end

	// --- assertions ------------------------------------------------------------
	`APWT_ASSERT_NEXT(a_finish_gives_done, state_q == FS_FINISH, done_q && !busy)
	`APWT_ASSERT_NOW(a_scan_in_range, state_q == FS_SCAN, int'(scan_q) < int'(n_q))
	`APWT_ASSERT_NOW(a_gap_only_on_miss, done_q && (res_q.miss_gap != '0), !res_q.accepted)
	`APWT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)

endmodule

`default_nettype wire

// ----- tb/audio_page_window_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_page_window_table_tb
// drives fill, cancel, publish, retire, lookup and query commands into the
// page table, keeps its own copy of the page table to predict each result,
// and compares every result field with the prediction across several
// active page / frame capacity settings
// ----------------------------------------------------------------------------

module audio_page_window_table_tb;

	import apwt_pkg::*;

	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          RANDOM_ITEMS = 1375;
	localparam int          PLAN_STRIDE  = 175;
	localparam int          SETTLE       = 16;
	localparam logic [47:0] FRAME_MAX    = 48'hFFFF_FFFF_FFFF;
	localparam logic [2:0]  OP_SPARE_LO  = 3'd6;
	localparam logic [2:0]  OP_SPARE_HI  = 3'd7;

	// page table copy: predicts one result per accepted command
	class page_window_tracker;
		logic [3:0]  active_cnt;
		logic [15:0] frames_max;
		pstate_t     pg_state[MAX_PAGES];
		logic [31:0] gen[MAX_PAGES];
		logic [47:0] st[MAX_PAGES];
		logic [15:0] cnt[MAX_PAGES];
		logic        fin[MAX_PAGES];
		logic [31:0] ret_after[MAX_PAGES];
		apwt_result_t pending_results[$];
		int errors;

		function new();
			active_cnt = ACTIVE_PAGES_RESET;
			frames_max = PAGE_FRAMES_RESET;
			errors = 0;
			for (int i = 0; i < MAX_PAGES; i++) begin
				pg_state[i] = PS_EMPTY;
				wipe_entry(i);
			end
		endfunction

		function void wipe_entry(int p);
			gen[p] = '0;
			st[p] = '0;
			cnt[p] = '0;
			fin[p] = 1'b0;
			ret_after[p] = '0;
		endfunction

		function apwt_result_t page_table_step(apwt_cmd_t c);
			apwt_result_t r;
			int live;
			int p;
			bit valid;
			bit ok;
			bit hit;
			logic [48:0] tail;
			logic [47:0] gap;
			logic [47:0] diff;
			r = '0;
			live = (active_cnt > MAX_PAGES) ? MAX_PAGES : active_cnt;
			valid = c.page < live;
			p = valid ? c.page : 0;
			case (c.operation)
				OP_BEGIN_FILL: begin
					if (valid && (pg_state[p] == PS_EMPTY || (pg_state[p] == PS_RETIRED &&
							c.audio_generation >= ret_after[p]))) begin
						pg_state[p] = PS_FILLING;
						wipe_entry(p);
						r.accepted = 1'b1;
					end
				end
				OP_CANCEL_FILL: begin
					if (valid && pg_state[p] == PS_FILLING) begin
						pg_state[p] = PS_EMPTY;
						wipe_entry(p);
						r.accepted = 1'b1;
					end
				end
				OP_PUBLISH: begin
					tail = {1'b0, c.first_frame} + {33'd0, c.frame_total};
					ok = valid && pg_state[p] == PS_FILLING && c.stream_gen != 0 &&
						c.frame_total != 0 && c.frame_total <= frames_max && !tail[48];
					// same-generation ready pages must not share any frame
					for (int i = 0; i < live; i++) begin
						if (ok && i != p && pg_state[i] == PS_READY &&
								gen[i] == c.stream_gen &&
								{1'b0, c.first_frame} < {1'b0, st[i]} + {33'd0, cnt[i]} &&
								{1'b0, st[i]} < tail)
							ok = 1'b0;
					end
					if (ok) begin
						gen[p] = c.stream_gen;
						st[p] = c.first_frame;
						cnt[p] = c.frame_total;
						fin[p] = c.final_flag;
						pg_state[p] = PS_READY;
						r.accepted = 1'b1;
					end
				end
				OP_RETIRE: begin
					if (valid && c.audio_generation != 0 && pg_state[p] == PS_READY) begin
						ret_after[p] = c.audio_generation;
						pg_state[p] = PS_RETIRED;
						r.accepted = 1'b1;
					end
				end
				OP_LOOKUP: begin
					gap = c.gap_limit;
					hit = 1'b0;
					if (c.stream_gen != 0) begin
						for (int i = 0; i < live; i++) begin
							diff = c.seek_frame - st[i];
							if (!hit && pg_state[i] == PS_READY &&
									gen[i] == c.stream_gen &&
									c.seek_frame >= st[i] && diff < {32'd0, cnt[i]}) begin
								hit = 1'b1;
								r.accepted = 1'b1;
								r.hit_page = 8'(i);
								r.page_offset = diff[15:0];
								r.hit_start = st[i];
								r.hit_frames = cnt[i];
								r.hit_final = fin[i];
							end
						end
						// distance to the nearest later ready page, capped by the limit
						if (!hit && c.gap_limit != 0) begin
							for (int i = 0; i < live; i++) begin
								if (pg_state[i] == PS_READY && gen[i] == c.stream_gen &&
										st[i] > c.seek_frame && st[i] - c.seek_frame < gap)
									gap = st[i] - c.seek_frame;
							end
						end
					end
					if (!hit)
						r.miss_gap = gap;
				end
				OP_QUERY: begin
					if (valid) begin
						r.accepted = 1'b1;
						r.state_code = pg_state[p];
					end
				end
				default: begin
				end
			endcase
			return r;
		endfunction

		function void take_command(apwt_cmd_t c);
			pending_results.push_back(page_table_step(c));
		endfunction

		function void compare_field(string name, logic [47:0] want, logic [47:0] got);
			if (got !== want) begin
				$display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_response(apwt_result_t got);
			apwt_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t result with nothing expected: %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("accepted", 48'(want.accepted), 48'(got.accepted));
			compare_field("state_code", 48'(want.state_code), 48'(got.state_code));
			compare_field("hit_page", 48'(want.hit_page), 48'(got.hit_page));
			compare_field("page_offset", 48'(want.page_offset), 48'(got.page_offset));
			compare_field("hit_start", want.hit_start, got.hit_start);
			compare_field("hit_frames", 48'(want.hit_frames), 48'(got.hit_frames));
			compare_field("hit_final", 48'(want.hit_final), 48'(got.hit_final));
			compare_field("miss_gap", want.miss_gap, got.miss_gap);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	apwt_cmd_t             cmd = '0;
	logic                  done;
	apwt_result_t          result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int                    cycle_count = 0;

	page_window_tracker ledger = new();

	audio_page_window_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result transfer first, then a command transfer at the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_response(result);
			if (start && !busy)
				ledger.take_command(cmd);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("audio_page_window_table verification failed");
			$finish;
		end
	end

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic apwt_cmd_t make_cmd(logic [2:0] op, logic [7:0] page,
			logic [31:0] sgen, logic [31:0] agen, logic [47:0] sf, logic [15:0] fc,
			logic ff, logic [47:0] src, logic [47:0] lim);
		apwt_cmd_t c;
		c.operation = op;
		c.page = page;
		c.stream_gen = sgen;
		c.audio_generation = agen;
		c.first_frame = sf;
		c.frame_total = fc;
		c.final_flag = ff;
		c.seek_frame = src;
		c.gap_limit = lim;
		return c;
	endfunction

	// mostly well-formed traffic aimed at pages whose state makes it meaningful
	function automatic apwt_cmd_t random_cmd();
		apwt_cmd_t c;
		int roll;
		int pick;
		int pk;
		c = make_cmd(3'($urandom), 8'($urandom), $urandom, $urandom, rand48(),
			16'($urandom), 1'($urandom), rand48(), rand48());
		pk = $urandom_range(0, MAX_PAGES - 1);
		if ($urandom_range(0, 99) >= 8)
			c.page = 8'(pk);
		pick = $urandom_range(0, 99);
		c.stream_gen = (pick < 5) ? 32'd0 : (pick < 10) ? $urandom : $urandom_range(1, 3);
		roll = $urandom_range(0, 99);
		if (roll < 17) begin
			c.operation = OP_BEGIN_FILL;
			if ($urandom_range(0, 99) < 85)
				c.audio_generation = $urandom_range(0, 48);
		end else if (roll < 22) begin
			c.operation = OP_CANCEL_FILL;
		end else if (roll < 45) begin
			c.operation = OP_PUBLISH;
			if (c.page < MAX_PAGES) begin
				for (int i = 0; i < MAX_PAGES; i++) begin
					if (ledger.pg_state[(pk + i) % MAX_PAGES] == PS_FILLING) begin
						c.page = 8'((pk + i) % MAX_PAGES);
						break;
					end
				end
			end
			pick = $urandom_range(0, 99);
			if (pick < 80)
				c.first_frame = 48'($urandom_range(0, 31) * 64 + $urandom_range(0, 2) * 16);
			else if (pick < 90)
				c.first_frame = FRAME_MAX - 48'($urandom_range(0, 200));
			pick = $urandom_range(0, 99);
			if (pick < 75)
				c.frame_total = 16'($urandom_range(1, 96));
			else if (pick < 81)
				c.frame_total = '0;
			else if (pick < 88)
				c.frame_total = ledger.frames_max;
			else if (pick < 94)
				c.frame_total = ledger.frames_max + 16'd1;
		end else if (roll < 57) begin
			c.operation = OP_RETIRE;
			pick = $urandom_range(0, 99);
			if (pick < 10)
				c.audio_generation = '0;
			else if (pick < 90)
				c.audio_generation = $urandom_range(1, 40);
		end else if (roll < 87) begin
			c.operation = OP_LOOKUP;
			if ($urandom_range(0, 99) < 70 && ledger.pg_state[pk] == PS_READY) begin
				c.stream_gen = ledger.gen[pk];
				c.seek_frame = ledger.st[pk] +
					48'($urandom_range(0, ledger.cnt[pk] + 6)) - 48'd3;
			end else if ($urandom_range(0, 99) < 90) begin
				c.seek_frame = 48'($urandom_range(0, 2100));
			end
			pick = $urandom_range(0, 99);
			if (pick < 10)
				c.gap_limit = '0;
			else if (pick < 60)
				c.gap_limit = 48'($urandom_range(1, 300));
			else if (pick < 80)
				c.gap_limit = FRAME_MAX;
		end else if (roll < 95) begin
			c.operation = OP_QUERY;
		end else begin
			c.operation = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
		end
		return c;
	endfunction

	task automatic issue(input apwt_cmd_t c, input bit may_idle);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		if (may_idle && $urandom_range(0, 99) < 23) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (ledger.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [3:0] pages, input logic [15:0] frames);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ACTIVE_PAGES;
		cfg_wdata <= CFG_DATA_W'(pages);
		@(posedge clk);
		cfg_index <= CFG_PAGE_FRAMES;
		cfg_wdata <= frames;
		@(posedge clk);
		cfg_we <= 1'b0;
		ledger.active_cnt = pages;
		ledger.frames_max = frames;
	endtask

	logic [3:0]  plan_pages[7]  = '{4'd1, 4'd8, 4'd0, 4'd4, 4'd15, 4'd3, 4'd8};
	logic [15:0] plan_frames[7] = '{16'd1, 16'd65535, 16'd100, 16'd0, 16'd4096, 16'd32,
		16'd200};

	initial begin
		int step;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: state rules, publish rejections, lookup hit and miss corners
		issue(make_cmd(OP_QUERY, 8'd0, '0, '0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_QUERY, 8'd200, '0, '0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_BEGIN_FILL, 8'd0, '0, '0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd0, 32'd0, '0, 48'd100, 16'd10, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd0, 32'd1, '0, 48'd100, 16'd0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd0, 32'd1, '0, 48'd100, 16'd4097, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd0, 32'd1, '0, FRAME_MAX - 48'd9, 16'd10, 1'b0, '0, '0),
			1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd0, 32'd1, '0, 48'd100, 16'd4096, 1'b1, '0, '0), 1'b1);
		issue(make_cmd(OP_BEGIN_FILL, 8'd1, '0, '0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd1, 32'd1, '0, 48'd4195, 16'd5, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd1, 32'd1, '0, 48'd4196, 16'd5, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_BEGIN_FILL, 8'd2, '0, '0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_PUBLISH, 8'd2, 32'hFFFF_FFFF, '0, FRAME_MAX - 48'd4096, 16'd4096,
			1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_LOOKUP, '0, 32'd1, '0, '0, '0, 1'b0, 48'd100, '0), 1'b1);
		issue(make_cmd(OP_LOOKUP, '0, 32'd1, '0, '0, '0, 1'b0, 48'd4195, '0), 1'b1);
		issue(make_cmd(OP_LOOKUP, '0, 32'd1, '0, '0, '0, 1'b0, 48'd40, 48'd1000), 1'b1);
		issue(make_cmd(OP_LOOKUP, '0, 32'd1, '0, '0, '0, 1'b0, 48'd40, 48'd7), 1'b1);
		issue(make_cmd(OP_LOOKUP, '0, 32'd1, '0, '0, '0, 1'b0, 48'd5000, 48'd0), 1'b1);
		issue(make_cmd(OP_LOOKUP, '0, 32'd0, '0, '0, '0, 1'b0, 48'd100, FRAME_MAX), 1'b1);
		issue(make_cmd(OP_LOOKUP, '0, 32'hFFFF_FFFF, '0, '0, '0, 1'b0, FRAME_MAX - 48'd1,
			48'd5), 1'b1);
		issue(make_cmd(OP_RETIRE, 8'd0, '0, 32'd0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_RETIRE, 8'd0, '0, 32'd5, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_BEGIN_FILL, 8'd0, '0, 32'd4, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_BEGIN_FILL, 8'd0, '0, 32'd5, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_CANCEL_FILL, 8'd0, '0, '0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_BEGIN_FILL, 8'd8, '0, '0, '0, '0, 1'b0, '0, '0), 1'b1);
		issue(make_cmd(OP_SPARE_LO, 8'd1, 32'd1, 32'd1, '1, '1, 1'b1, '1, '1), 1'b1);
		issue(make_cmd(OP_SPARE_HI, 8'd1, 32'd1, 32'd1, '1, '1, 1'b1, '1, '1), 1'b1);

		for (step = 0; step < RANDOM_ITEMS; step++) begin
			if (step > 0 && step % PLAN_STRIDE == 0)
				set_config(plan_pages[step / PLAN_STRIDE - 1],
					plan_frames[step / PLAN_STRIDE - 1]);
			// no random idle gaps from the sender in this stretch
			issue(random_cmd(), !(step >= 700 && step < 950));
		end

		drain();
		if (ledger.errors == 0)
			$display("audio_page_window_table verification clean");
		else
			$display("audio_page_window_table verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/apwt_pkg.sv
rtl/audio_page_window_table.sv
tb/audio_page_window_table_tb.sv
